// ----- rtl/core/sslt_pkg.sv -----
// ----------------------------------------------------------------------------
// sslt_pkg
// Shared types, request codes and sizing constants for the sorted span
// lookup table.
// ----------------------------------------------------------------------------
package sslt_pkg;

  // Field widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned COUNT_W = 9;

  // Default table depth and reduction group size
  localparam int unsigned DEF_TABLE_DEPTH = 256;
  localparam int unsigned GROUP_SIZE      = 16;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 16;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_type_t;

  // One stored span
  typedef struct packed {
    logic [POS_W-1:0]  start;
    logic [POS_W-1:0]  stop;
    logic [KIND_W-1:0] kind;
  } span_t;

  // Control broadcast from the top level to every cell
  typedef struct packed {
    logic             push_en;   // insert the new span this cycle
    logic             query_en;  // capture the lookup result this cycle
    logic             load_en;   // any accepted beat
    span_t            new_span;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ----- rtl/core/sslt_cell.sv -----
// ----------------------------------------------------------------------------
// sslt_cell
// One slot of the sorted table. Holds a span, decides locally whether to
// keep it, take the new span, or take its lower neighbor's span on insert,
// and registers its share of a lookup result.
// ----------------------------------------------------------------------------
module sslt_cell (
  input  logic                         clk,
  input  sslt_pkg::cell_ctl_t          ctl,
  input  logic                         occ,          // slot holds a valid span
  input  logic                         prev_stay,    // lower neighbor stays put
  input  sslt_pkg::span_t              prev_span,    // lower neighbor's span
  input  logic                         next_le,      // upper neighbor start <= pos
  output logic                         stay,         // this slot stays put
  output logic                         le,           // this slot start <= pos
  output sslt_pkg::span_t              span,
  output logic [sslt_pkg::KIND_W-1:0]  contrib_r
);

  sslt_pkg::span_t                    span_r;
  sslt_pkg::span_t                    span_nxt;
  logic [sslt_pkg::KIND_W-1:0]        contrib_nxt;
  logic                               boundary;

  assign span = span_r;

  // Order test: stored span sorts at or ahead of the new one
  always_comb begin
    if (span_r.start != ctl.new_span.start) begin
      stay = occ && (span_r.start < ctl.new_span.start);
    end else begin
      stay = occ && (span_r.kind <= ctl.new_span.kind);
    end
  end

  // Keep, take the new span, or shift up from below
  always_comb begin
    span_nxt = span_r;
    if (ctl.push_en && !stay) begin
      if (prev_stay) begin
        span_nxt = ctl.new_span;
      end else begin
        span_nxt = prev_span;
      end
    end
  end

  // The last slot with start <= pos answers the lookup
  assign le       = occ && (span_r.start <= ctl.pos);
  assign boundary = le && !next_le;

  always_comb begin
    contrib_nxt = '0;
    if (ctl.query_en && boundary && (ctl.pos < span_r.stop)) begin
      contrib_nxt = span_r.kind;
    end
  end

  always_ff @(posedge clk) begin
    span_r <= span_nxt;
    if (ctl.load_en) begin
      contrib_r <= contrib_nxt;
    end
  end

endmodule

// ----- rtl/core/sslt_reduce.sv -----
// ----------------------------------------------------------------------------
// sslt_reduce
// Registered OR merge of kind codes. At most one input is nonzero, so the
// OR picks out the single hit.
// ----------------------------------------------------------------------------
module sslt_reduce #(
  parameter int unsigned N_IN = sslt_pkg::GROUP_SIZE
) (
  input  logic                                     clk,
  input  logic [N_IN-1:0][sslt_pkg::KIND_W-1:0]    din,
  output logic [sslt_pkg::KIND_W-1:0]              dout_r
);

  logic [sslt_pkg::KIND_W-1:0] dout_nxt;

  // Merge all inputs
  always_comb begin
    dout_nxt = '0;
    for (int unsigned k = 0; k < N_IN; k++) begin
      dout_nxt = dout_nxt | din[k];
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

endmodule

// ----- rtl/core/sorted_span_lookup_table.sv -----
// Pipeline: the lookup is registered in the cell row, and two registered
//   OR stages merge the hit. A new request is taken only once the result
//   beat of the last one has been taken, so an output stall holds it back.
// Reset: synchronous, active low; clears the span count, the drop flag and
//   the sequencer. Spans are not cleared; no clearing pass runs after reset.
// ----------------------------------------------------------------------------
// sorted_span_lookup_table
// Table of spans kept sorted by start, kind and arrival in a row of cells.
// Handles clear, push and position lookup requests, one result per request.
// ----------------------------------------------------------------------------
module sorted_span_lookup_table #(
  parameter int unsigned TABLE_DEPTH = sslt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: span_start[31:0], span_end[63:32], span_kind[66:64],
  //        query_pos[98:67], zero pad[103:99]
  input  logic [sslt_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: req_type[1:0]
  input  logic [sslt_pkg::REQ_W-1:0]        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: hit_kind[2:0], push_dropped[3], entry_count[12:4], zero pad[15:13]
  output logic [sslt_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NGROUP  =
    (TABLE_DEPTH + sslt_pkg::GROUP_SIZE - 1) / sslt_pkg::GROUP_SIZE;
  localparam int unsigned PAD_N   = NGROUP * sslt_pkg::GROUP_SIZE;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CELL = 4'b0010,
    S_GRP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t                                   state_r, state_nxt;
  logic [CNT_W-1:0]                         total_r, total_nxt;
  logic                                     dropped_r, dropped_nxt;

  logic                                     in_acc;
  sslt_pkg::req_type_t                      req;
  logic                                     push_ok;
  logic                                     full;
  sslt_pkg::cell_ctl_t                      ctl;

  logic [TABLE_DEPTH-1:0]                   occ;
  logic [TABLE_DEPTH-1:0]                   stay;
  logic [TABLE_DEPTH-1:0]                   le;
  sslt_pkg::span_t                          span_q [TABLE_DEPTH];
  logic [PAD_N-1:0][sslt_pkg::KIND_W-1:0]   contrib;
  logic [NGROUP-1:0][sslt_pkg::KIND_W-1:0]  grp_kind;
  logic [sslt_pkg::KIND_W-1:0]              hit_kind;
  logic [sslt_pkg::COUNT_W-1:0]             count_out;

  // Decode the input beat
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign req       = sslt_pkg::req_type_t'(in_tuser);

  assign ctl.new_span.start = in_tdata[31:0];
  assign ctl.new_span.stop  = in_tdata[63:32];
  assign ctl.new_span.kind  = in_tdata[66:64];
  assign ctl.pos            = in_tdata[98:67];

  assign full     = (total_r == CNT_W'(TABLE_DEPTH));
  assign push_ok  = in_acc && (req == sslt_pkg::REQ_PUSH) &&
                    (ctl.new_span.start < ctl.new_span.stop);
  assign ctl.push_en  = push_ok && !full;
  assign ctl.query_en = in_acc && (req == sslt_pkg::REQ_QUERY);
  assign ctl.load_en  = in_acc;

  // Row of cells
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic            prev_stay;
    sslt_pkg::span_t prev_span;
    logic            next_le;

    assign occ[i] = (IDX < total_r);

    if (i == 0) begin : g_first
      assign prev_stay = 1'b1;
      assign prev_span = ctl.new_span;
    end else begin : g_rest
      assign prev_stay = stay[i-1];
      assign prev_span = span_q[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign next_le = 1'b0;
    end else begin : g_mid
      assign next_le = le[i+1];
    end

    sslt_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ[i]),
      .prev_stay   (prev_stay),
      .prev_span   (prev_span),
      .next_le     (next_le),
      .stay        (stay[i]),
      .le          (le[i]),
      .span        (span_q[i]),
      .contrib_r   (contrib[i])
    );
  end

  // Zero the padding slots of the last group
  for (genvar p = TABLE_DEPTH; p < PAD_N; p++) begin : g_pad
    assign contrib[p] = '0;
  end

  // First merge stage: one register per group of cells
  for (genvar g = 0; g < NGROUP; g++) begin : g_grp
    sslt_reduce #(
      .N_IN (sslt_pkg::GROUP_SIZE)
    ) u_grp (
      .clk    (clk),
      .din    (contrib[g*sslt_pkg::GROUP_SIZE +: sslt_pkg::GROUP_SIZE]),
      .dout_r (grp_kind[g])
    );
  end

  // Second merge stage: final hit register
  sslt_reduce #(
    .N_IN (NGROUP)
  ) u_final (
    .clk    (clk),
    .din    (grp_kind),
    .dout_r (hit_kind)
  );

  // Count and drop flag
  always_comb begin
    total_nxt   = total_r;
    dropped_nxt = dropped_r;
    if (in_acc) begin
      dropped_nxt = push_ok && full;
      if (req == sslt_pkg::REQ_CLEAR) begin
        total_nxt = '0;
      end else if (ctl.push_en) begin
        total_nxt = total_r + CNT_W'(1);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_CELL;
      end
      S_CELL: state_nxt = S_GRP;
      S_GRP:  state_nxt = S_OUT;
      S_OUT: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  // Result beat
  assign count_out  = sslt_pkg::COUNT_W'(total_r);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, count_out, dropped_r, hit_kind};

endmodule

// ----- rtl/core/sslt_checker.sv -----
// ----------------------------------------------------------------------------
// sslt_checker
// Port-level checks for the sorted span lookup table, bound to the top level.
// ----------------------------------------------------------------------------
module sslt_checker #(
  parameter int unsigned TABLE_DEPTH = sslt_pkg::DEF_TABLE_DEPTH
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [sslt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready
);

  localparam logic [sslt_pkg::COUNT_W-1:0] DEPTH_CNT =
    sslt_pkg::COUNT_W'(TABLE_DEPTH);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // One request in flight: no new beat taken right after one is taken
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in flight");

  // No input taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // A dropped push only happens on a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[12:4] == DEPTH_CNT)
    else $error("push dropped with room left");

  // A dropped push never reports a hit kind
  a_drop_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> out_tdata[2:0] == 3'd0)
    else $error("dropped push carries a hit kind");

endmodule

bind sorted_span_lookup_table sslt_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_sslt_checker (.*);
